>>> rtl/core/prce_pkg.sv
// ----------------------------------------------------------------------------
// prce_pkg
// Shared types, codes and the colour conversion for the palette colour encoder.
// ----------------------------------------------------------------------------
package prce_pkg;

  localparam int PALETTE_ENTRIES = 512;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W         = 16;
  localparam int BLANK_CNT_W     = 4;

  localparam logic [7:0]  CONTROL_MASK = 8'h87;
  localparam logic [15:0] COLOR_MASK   = 16'h7ffe;
  localparam logic [15:0] SPRITE_TAG   = 16'h8000;
  localparam logic [15:0] BG_TAG       = 16'h0001;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_ADDR_LO = 3'd2;
  localparam logic [2:0] REG_ADDR_HI = 3'd3;
  localparam logic [2:0] REG_DATA_LO = 3'd4;
  localparam logic [2:0] REG_DATA_HI = 3'd5;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

  // input beat, last field in the lowest bits
  typedef struct packed {
    logic [ADDR_W-1:0] color_index;
    logic [7:0]        write_data;
    logic [2:0]        reg_addr;
    cmd_t              command;
  } item_t;

  function automatic logic [4:0] level5(input logic [2:0] v);
    logic [4:0] r;
    case (v)
      3'd0:    r = 5'd0;
      3'd1:    r = 5'd4;
      3'd2:    r = 5'd9;
      3'd3:    r = 5'd13;
      3'd4:    r = 5'd18;
      3'd5:    r = 5'd22;
      3'd6:    r = 5'd27;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // grb 3:3:3 to blue 14..10, green 9..5, red 4..0, tag bits cleared
  function automatic logic [15:0] grb_to_rgba(input logic [8:0] c);
    logic [15:0] v;
    v = {1'b0, level5(c[2:0]), level5(c[8:6]), level5(c[5:3])};
    return v & COLOR_MASK;
  endfunction

endpackage

>>> rtl/core/prce_ram.sv
// ----------------------------------------------------------------------------
// prce_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module prce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/prce_ctrl.sv
// ----------------------------------------------------------------------------
// prce_ctrl
// Sequencer: register decode, read-modify-write of the raw palette,
// conversion into the colour palette, blank-slot sweeps and the reset clear.
// ----------------------------------------------------------------------------
module prce_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  prce_pkg::item_t               s_item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_read_data,
  output logic [prce_pkg::COLOR_W-1:0]  m_color,
  // raw palette port
  output logic                          raw_we,
  output logic [prce_pkg::ADDR_W-1:0]   raw_waddr,
  output logic [prce_pkg::COLOR_W-1:0]  raw_wdata,
  output logic                          raw_re,
  output logic [prce_pkg::ADDR_W-1:0]   raw_raddr,
  input  logic [prce_pkg::COLOR_W-1:0]  raw_rdata,
  // converted palette port
  output logic                          cnv_we,
  output logic [prce_pkg::ADDR_W-1:0]   cnv_waddr,
  output logic [prce_pkg::COLOR_W-1:0]  cnv_wdata,
  output logic                          cnv_re,
  output logic [prce_pkg::ADDR_W-1:0]   cnv_raddr,
  input  logic [prce_pkg::COLOR_W-1:0]  cnv_rdata
);

  prce_pkg::state_t                    state, state_next;
  prce_pkg::item_t                     cur;
  logic [prce_pkg::ADDR_W-1:0]         addr, addr_next;
  logic [7:0]                          control_byte, control_byte_next;
  logic [prce_pkg::ADDR_W-1:0]         clear_cnt, clear_cnt_next;
  logic [prce_pkg::BLANK_CNT_W-1:0]    sweep_cnt, sweep_cnt_next;
  logic                                sweep_hi, sweep_hi_next;
  logic [prce_pkg::COLOR_W-1:0]        sweep_val, sweep_val_next;
  logic                                out_valid, out_valid_next;
  logic [7:0]                          out_rd, out_rd_next;
  logic [prce_pkg::COLOR_W-1:0]        out_col, out_col_next;

  logic                                accept;
  logic                                exec_go;
  logic [prce_pkg::COLOR_W-1:0]        conv;

  assign s_tready    = (state == prce_pkg::ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign m_tvalid    = out_valid;
  assign m_read_data = out_rd;
  assign m_color     = out_col;

  assign raw_re    = accept;
  assign raw_raddr = addr;
  assign cnv_re    = accept;
  assign cnv_raddr = s_item.color_index;

  // execute waits for the output register to free up
  assign exec_go = (state == prce_pkg::ST_EXEC) && (!out_valid || m_tready);
  assign conv    = prce_pkg::grb_to_rgba({cur.write_data[0], raw_rdata[7:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= prce_pkg::ST_CLEAR;
      addr         <= '0;
      control_byte <= '0;
      clear_cnt    <= '0;
      sweep_cnt    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      addr         <= addr_next;
      control_byte <= control_byte_next;
      clear_cnt    <= clear_cnt_next;
      sweep_cnt    <= sweep_cnt_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= s_item;
    end
    sweep_hi  <= sweep_hi_next;
    sweep_val <= sweep_val_next;
    out_rd    <= out_rd_next;
    out_col   <= out_col_next;
  end

  always_comb begin
    state_next        = state;
    addr_next         = addr;
    control_byte_next = control_byte;
    clear_cnt_next    = clear_cnt;
    sweep_cnt_next    = sweep_cnt;
    sweep_hi_next     = sweep_hi;
    sweep_val_next    = sweep_val;
    out_valid_next    = out_valid && !m_tready;
    out_rd_next       = out_rd;
    out_col_next      = out_col;
    raw_we            = 1'b0;
    raw_waddr         = addr;
    raw_wdata         = raw_rdata;
    cnv_we            = 1'b0;
    cnv_waddr         = addr;
    cnv_wdata         = conv;

    unique case (state)
      prce_pkg::ST_CLEAR: begin
        raw_we    = 1'b1;
        raw_waddr = clear_cnt;
        raw_wdata = '0;
        cnv_we    = 1'b1;
        cnv_waddr = clear_cnt;
        cnv_wdata = '0;
        clear_cnt_next = clear_cnt + 1'b1;
        if (clear_cnt == prce_pkg::ADDR_W'(prce_pkg::PALETTE_ENTRIES - 1)) begin
          state_next = prce_pkg::ST_IDLE;
        end
      end
      prce_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = prce_pkg::ST_EXEC;
        end
      end
      prce_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_next     = prce_pkg::ST_IDLE;
          out_valid_next = 1'b1;
          out_rd_next    = '0;
          out_col_next   = '0;
          unique case (cur.command)
            prce_pkg::CMD_WRITE: begin
              case (cur.reg_addr)
                prce_pkg::REG_CONTROL:
                  control_byte_next = cur.write_data & prce_pkg::CONTROL_MASK;
                prce_pkg::REG_ADDR_LO: addr_next = {addr[8], cur.write_data};
                prce_pkg::REG_ADDR_HI: addr_next = {cur.write_data[0], addr[7:0]};
                prce_pkg::REG_DATA_LO: begin
                  raw_we    = 1'b1;
                  raw_wdata = {raw_rdata[15:8], cur.write_data};
                end
                prce_pkg::REG_DATA_HI: begin
                  raw_we    = 1'b1;
                  raw_wdata = {cur.write_data, raw_rdata[7:0]};
                  addr_next = addr + 1'b1;
                  if (addr[7:0] == 8'd0) begin
                    // entry 0 or 256 fills every blank slot of its half
                    state_next     = prce_pkg::ST_SWEEP;
                    sweep_cnt_next = '0;
                    sweep_hi_next  = addr[8];
                    sweep_val_next = conv;
                  end else if (addr[8]) begin
                    cnv_we    = 1'b1;
                    cnv_wdata = conv | prce_pkg::SPRITE_TAG;
                  end else if (addr[3:0] != 4'd0) begin
                    cnv_we    = 1'b1;
                    cnv_wdata = conv | prce_pkg::BG_TAG;
                  end
                end
                default: ;
              endcase
            end
            prce_pkg::CMD_READ: begin
              if (cur.reg_addr == prce_pkg::REG_DATA_LO) begin
                out_rd_next = raw_rdata[7:0];
              end else if (cur.reg_addr == prce_pkg::REG_DATA_HI) begin
                out_rd_next = raw_rdata[15:8];
                addr_next   = addr + 1'b1;
              end
            end
            prce_pkg::CMD_LOOKUP: out_col_next = cnv_rdata;
            default: ;
          endcase
        end
      end
      prce_pkg::ST_SWEEP: begin
        cnv_we         = 1'b1;
        cnv_waddr      = {sweep_hi, sweep_cnt, 4'd0};
        cnv_wdata      = sweep_val;
        sweep_cnt_next = sweep_cnt + 1'b1;
        if (sweep_cnt == '1) begin
          state_next = prce_pkg::ST_IDLE;
        end
      end
      default: state_next = prce_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/palette_ram_color_encoder.sv
// ----------------------------------------------------------------------------
// palette_ram_color_encoder
// Byte-register palette colour encoder with raw and converted palette RAMs.
// ----------------------------------------------------------------------------
// channel  dir  fields (lowest bit up)
// s_*      in   command[1:0] reg_addr[4:2] write_data[12:5] color_index[21:13]
// m_*      out  read_data[7:0] color[23:8]
//
// an item is accepted only in idle, where the palette RAM reads are issued;
// the execute state then uses the registered read data and writes back
// a data high write to entry 0 or 256 adds a sweep of converted RAM writes
// after reset both RAMs are cleared, one entry a cycle, all 512 entries
// a full output register holds the item in its execute cycle until taken
// ----------------------------------------------------------------------------
module palette_ram_color_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command, reg_addr, write_data, color_index, zero pad
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data, color
  output logic [23:0] m_tdata
);

  prce_pkg::item_t                     item;
  logic [7:0]                          read_data;
  logic [prce_pkg::COLOR_W-1:0]        color;
  logic                                raw_we, raw_re, cnv_we, cnv_re;
  logic [prce_pkg::ADDR_W-1:0]         raw_waddr, raw_raddr, cnv_waddr, cnv_raddr;
  logic [prce_pkg::COLOR_W-1:0]        raw_wdata, raw_rdata, cnv_wdata, cnv_rdata;

  assign item    = prce_pkg::item_t'(s_tdata[21:0]);
  assign m_tdata = {color, read_data};

  prce_ram #(
    .WIDTH (prce_pkg::COLOR_W),
    .DEPTH (prce_pkg::PALETTE_ENTRIES)
  ) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (raw_waddr),
    .wdata (raw_wdata),
    .re    (raw_re),
    .raddr (raw_raddr),
    .rdata (raw_rdata)
  );

  prce_ram #(
    .WIDTH (prce_pkg::COLOR_W),
    .DEPTH (prce_pkg::PALETTE_ENTRIES)
  ) u_cnv_ram (
    .clk   (clk),
    .we    (cnv_we),
    .waddr (cnv_waddr),
    .wdata (cnv_wdata),
    .re    (cnv_re),
    .raddr (cnv_raddr),
    .rdata (cnv_rdata)
  );

  prce_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_item      (item),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_read_data (read_data),
    .m_color     (color),
    .raw_we      (raw_we),
    .raw_waddr   (raw_waddr),
    .raw_wdata   (raw_wdata),
    .raw_re      (raw_re),
    .raw_raddr   (raw_raddr),
    .raw_rdata   (raw_rdata),
    .cnv_we      (cnv_we),
    .cnv_waddr   (cnv_waddr),
    .cnv_wdata   (cnv_wdata),
    .cnv_re      (cnv_re),
    .cnv_raddr   (cnv_raddr),
    .cnv_rdata   (cnv_rdata)
  );

endmodule

>>> tb/tb_palette_ram_color_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_ram_color_encoder
// Drives register writes, register reads and colour lookups into the encoder
// and checks every reply against a shadow of the address, the raw palette
// and the converted palette kept by a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_palette_ram_color_encoder;
  import prce_pkg::*;

  localparam int TOTAL_ITEMS = 1250;
  localparam int HALF        = PALETTE_ENTRIES / 2;

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  read_data;
  } reply_t;

  class encoder_shadow;
    logic [ADDR_W-1:0] pal_addr;
    logic [7:0]        ctrl;
    logic [15:0]       raw [PALETTE_ENTRIES];
    logic [15:0]       conv [PALETTE_ENTRIES];
    logic [4:0]        steps [8];
    reply_t            pending_replies [$];
    int                errors;

    function new();
      steps = '{5'd0, 5'd4, 5'd9, 5'd13, 5'd18, 5'd22, 5'd27, 5'd31};
      foreach (raw[i]) begin
        raw[i]  = '0;
        conv[i] = '0;
      end
      pal_addr = '0;
      ctrl     = '0;
      errors   = 0;
    endfunction

    // green 8..6, red 5..3, blue 2..0 in; blue 14..10, green 9..5, red 4..0 out
    function logic [15:0] to_rgb555(logic [8:0] grb);
      logic [15:0] v;
      v = {1'b0, steps[grb[2:0]], steps[grb[8:6]], steps[grb[5:3]]};
      return v & COLOR_MASK;
    endfunction

    function void store_high(logic [7:0] d);
      logic [ADDR_W-1:0] n;
      logic [15:0]       c;
      n = pal_addr;
      raw[n][15:8] = d;
      c = to_rgb555(raw[n][8:0]);
      if (n == 0) begin
        for (int i = 0; i < HALF; i += 16) conv[i] = c;
      end else if (n == HALF) begin
        for (int i = HALF; i < PALETTE_ENTRIES; i += 16) conv[i] = c;
      end else if (n[8]) begin
        conv[n] = c | SPRITE_TAG;
      end else if (n[3:0] != 4'd0) begin
        conv[n] = c | BG_TAG;
      end
      // background blank slots other than entry 0 leave the converted palette alone
      pal_addr = pal_addr + 1'b1;
    endfunction

    function void note_access(item_t it);
      reply_t r;
      logic [ADDR_W-1:0] n;
      r = '0;
      n = pal_addr;
      case (it.command)
        CMD_WRITE: begin
          case (it.reg_addr)
            REG_CONTROL: ctrl = it.write_data & CONTROL_MASK;
            REG_ADDR_LO: pal_addr[7:0] = it.write_data;
            REG_ADDR_HI: pal_addr[8] = it.write_data[0];
            REG_DATA_LO: raw[n][7:0] = it.write_data;
            REG_DATA_HI: store_high(it.write_data);
            default: ;
          endcase
        end
        CMD_READ: begin
          if (it.reg_addr == REG_DATA_LO) begin
            r.read_data = raw[n][7:0];
          end else if (it.reg_addr == REG_DATA_HI) begin
            r.read_data = raw[n][15:8];
            pal_addr = pal_addr + 1'b1;
          end
        end
        CMD_LOOKUP: r.color = conv[it.color_index];
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    task report(string what);
      if (errors < 100) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply %h with nothing outstanding", got));
      end else begin
        want = pending_replies.pop_front();
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
        if (got.color !== want.color)
          report($sformatf("color %h, expected %h", got.color, want.color));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  encoder_shadow sb = new();
  int src_idle_pct;
  int sink_stall_pct;
  int issued;

  palette_ram_color_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // entered and left at a falling edge; tvalid stays up between back-to-back beats
  task automatic put(cmd_t c, logic [2:0] r, logic [7:0] d, logic [8:0] x);
    item_t it;
    it.command     = c;
    it.reg_addr    = r;
    it.write_data  = d;
    it.color_index = x;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= 24'(it);
    do @(posedge clk); while (!s_tready);
    sb.note_access(it);
    if (c != CMD_NONE) issued++;
    @(negedge clk);
  endtask

  // hold off until every reply is in, plus room for a blank-slot sweep
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_address(logic [8:0] a);
    put(CMD_WRITE, REG_ADDR_LO, a[7:0], 9'($urandom));
    put(CMD_WRITE, REG_ADDR_HI, {7'($urandom), a[8]}, 9'($urandom));
  endtask

  task automatic directed_items();
    put(CMD_READ,   REG_CONTROL, 8'h00, 9'h000);
    put(CMD_WRITE,  REG_CONTROL, 8'hff, 9'h1ff);
    put(CMD_READ,   REG_CONTROL, 8'hff, 9'h000);
    // entry 0 fills the background blank slots
    put(CMD_WRITE,  REG_DATA_LO, 8'hff, 9'h000);
    put(CMD_WRITE,  REG_DATA_HI, 8'h01, 9'h000);
    put(CMD_LOOKUP, REG_CONTROL, 8'h00, 9'd240);
    // entry 256 fills the sprite blank slots; high address bit from bit 0 only
    put(CMD_WRITE,  REG_ADDR_LO, 8'h00, 9'h000);
    put(CMD_WRITE,  REG_ADDR_HI, 8'hff, 9'h000);
    put(CMD_WRITE,  REG_DATA_LO, 8'h55, 9'h000);
    put(CMD_WRITE,  REG_DATA_HI, 8'hfe, 9'h000);
    put(CMD_WRITE,  REG_DATA_HI, 8'h01, 9'h000);
    put(CMD_LOOKUP, REG_CONTROL, 8'h00, 9'd496);
    put(CMD_LOOKUP, REG_CONTROL, 8'h00, 9'd257);
    // background blank slot other than 0, then a tagged background entry
    set_address(9'd16);
    put(CMD_WRITE,  REG_DATA_HI, 8'hff, 9'h000);
    put(CMD_WRITE,  REG_DATA_HI, 8'h00, 9'h000);
    put(CMD_LOOKUP, REG_CONTROL, 8'h00, 9'd16);
    put(CMD_LOOKUP, REG_CONTROL, 8'h00, 9'd17);
    // read-back across the top of the address range
    set_address(9'h1ff);
    put(CMD_READ,   REG_DATA_LO, 8'h00, 9'h000);
    put(CMD_READ,   REG_DATA_HI, 8'h00, 9'h000);
    put(CMD_READ,   REG_DATA_HI, 8'h00, 9'h000);
    put(CMD_WRITE,  3'd7,        8'hff, 9'h1ff);
    put(CMD_READ,   REG_ADDR_LO, 8'h00, 9'h000);
    put(CMD_NONE,   3'd6,        8'hff, 9'h1ff);
  endtask

  task automatic palette_burst();
    logic [8:0] base;
    int k;
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       base = 9'd0;
      1:       base = 9'(HALF);
      2:       base = 9'(16 * $urandom_range(31));
      default: base = 9'($urandom_range(511));
    endcase
    k = $urandom_range(1, 4);
    set_address(base);
    for (int j = 0; j < k; j++) begin
      if ($urandom_range(1)) put(CMD_WRITE, REG_DATA_LO, 8'($urandom), 9'($urandom));
      put(CMD_WRITE, REG_DATA_HI, 8'($urandom), 9'($urandom));
    end
    for (int j = 0; j < k; j++)
      put(CMD_LOOKUP, 3'($urandom), 8'($urandom), base + 9'(j));
    if (base[7:0] == 8'd0)
      put(CMD_LOOKUP, 3'($urandom), 8'($urandom), base + 9'(16 * $urandom_range(15)));
    if ($urandom_range(2) == 0) begin
      set_address(base);
      put(CMD_READ, REG_DATA_LO, 8'($urandom), 9'($urandom));
      put(CMD_READ, REG_DATA_HI, 8'($urandom), 9'($urandom));
    end
  endtask

  task automatic random_items();
    int pick;
    int phase;
    int base_count;
    phase = -1;
    base_count = issued;
    while (issued - base_count < TOTAL_ITEMS) begin
      if ((issued - base_count) * 4 / TOTAL_ITEMS != phase) begin
        phase = (issued - base_count) * 4 / TOTAL_ITEMS;
        drain();
        case (phase)
          0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
          1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
          2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
          default: begin src_idle_pct = 29; sink_stall_pct = 29; end
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        palette_burst();
      end else if (pick < 60) begin
        put(CMD_LOOKUP, 3'($urandom), 8'($urandom),
            $urandom_range(1) ? 9'($urandom) : 9'(16 * $urandom_range(31)));
      end else if (pick < 72) begin
        put(CMD_READ, $urandom_range(1) ? REG_DATA_LO : REG_DATA_HI,
            8'($urandom), 9'($urandom));
      end else if (pick < 90) begin
        put(cmd_t'($urandom_range(3)), 3'($urandom), 8'($urandom), 9'($urandom));
      end else begin
        put(CMD_WRITE, $urandom_range(1) ? REG_CONTROL : REG_DATA_LO,
            8'($urandom), 9'($urandom));
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    issued         = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_items();
    drain();
    random_items();
    drain();
    if (sb.pending_replies.size() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.pending_replies.size()));
    if (sb.errors == 0) begin
      $display("tb_palette_ram_color_encoder passed");
    end else begin
      $display("tb_palette_ram_color_encoder failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_palette_ram_color_encoder failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/prce_pkg.sv
rtl/core/prce_ram.sv
rtl/core/prce_ctrl.sv
rtl/core/palette_ram_color_encoder.sv
tb/tb_palette_ram_color_encoder.sv
